### hdl/booth_radix2_signed_multiplier_core_defines.svh
// assertion macros for the booth radix-2 multiplier core
// no dependencies; included by modules that carry concurrent checks
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_CORE_DEFINES_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_CORE_DEFINES_SVH

// check a property outside reset
`define BRM_ASSERT(lbl, clk_i, rstn_i, prop_i, msg_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop_i) \
		else $error(msg_i);

// check a property at every edge, reset included
`define BRM_ASSERT_ALWAYS(lbl, clk_i, prop_i, msg_i) \
	lbl: assert property (@(posedge clk_i) prop_i) \
		else $error(msg_i);

`endif

### hdl/brm_pkg.sv
// shared constants, types and the booth recoding function
// no dependencies; imported by brm_cell and the top level
package brm_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned PROD_W        = 64;
	localparam int unsigned WIDTH_DEFAULT = 32;

	typedef enum logic [1:0] {
		BOOTH_NOP,
		BOOTH_ADD,
		BOOTH_SUB
	} booth_op_t;

	// radix-2 recoding of the pair (q bit 0, q-1)
	function automatic booth_op_t booth_decode(input logic q0, input logic qp);
		booth_op_t op;
		case ({q0, qp})
			2'b01:   op = BOOTH_ADD;
			2'b10:   op = BOOTH_SUB;
			default: op = BOOTH_NOP;
		endcase
		return op;
	endfunction

endpackage

### hdl/brm_cell.sv
// one booth step cell: add/subtract of the multiplicand, then shift right of A:Q:Q-1
// depends on brm_pkg
module brm_cell #(
	parameter int unsigned W = brm_pkg::WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W:0]   in_a,
	input  logic [W-1:0] in_q,
	input  logic         in_qp,
	input  logic [W-1:0] in_m,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W:0]   out_a,
	output logic [W-1:0] out_q,
	output logic         out_qp,
	output logic [W-1:0] out_m
);
	import brm_pkg::*;

	booth_op_t    op;
	logic [W:0]   m_ext;
	logic [W:0]   sum;
	logic         load;
	logic         valid_q;
	logic [W:0]   a_q;
	logic [W-1:0] q_q;
	logic         qp_q;
	logic [W-1:0] m_q;

	// local ready: empty or the next cell takes our item
	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	// booth add/subtract on the one-bit-wider accumulator
	always_comb begin
		m_ext = {in_m[W-1], in_m};
		op    = booth_decode(in_q[0], in_qp);
		case (op)
			BOOTH_ADD: sum = in_a + m_ext;
			BOOTH_SUB: sum = in_a - m_ext;
			default:   sum = in_a;
		endcase
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload with arithmetic shift right of A:Q:Q-1
	always_ff @(posedge clk) begin
		if (load) begin
			a_q  <= {sum[W], sum[W:1]};
			q_q  <= {sum[0], in_q[W-1:1]};
			qp_q <= in_q[0];
			m_q  <= in_m;
		end
	end

	assign out_valid = valid_q;
	assign out_a     = a_q;
	assign out_q     = q_q;
	assign out_qp    = qp_q;
	assign out_m     = m_q;

endmodule

### hdl/booth_radix2_signed_multiplier_core.sv
// one item per cycle unless stalled; a row of WIDTH booth cells, one step and one register each
// stalls back up cell by cell, so empty cells keep taking items while a product waits
// reset: arst_n clears every cell's valid bit at once; payload registers are not reset
// top level of the booth radix-2 multiplier; depends on brm_pkg, brm_cell and
// booth_radix2_signed_multiplier_core_defines.svh
module booth_radix2_signed_multiplier_core #(
	parameter int unsigned WIDTH = brm_pkg::WIDTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [31:0] multiplicand, [63:32] multiplier
	input  logic [2*brm_pkg::DATA_W-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [63:0] product
	output logic [brm_pkg::PROD_W-1:0]   m_axis_tdata
);
	import brm_pkg::*;
	`include "booth_radix2_signed_multiplier_core_defines.svh"

	localparam int unsigned FULL_W = 2 * WIDTH + 1;

	logic               valid_c [0:WIDTH];
	logic               ready_c [0:WIDTH];
	logic [WIDTH:0]     a_c     [0:WIDTH];
	logic [WIDTH-1:0]   q_c     [0:WIDTH];
	logic               qp_c    [0:WIDTH];
	logic [WIDTH-1:0]   m_c     [0:WIDTH];
	logic [FULL_W-1:0]  full_prod;
	logic signed [PROD_W:0] ext_prod;

	// chain head: A = 0, Q = multiplier, Q-1 = 0
	assign valid_c[0]    = s_axis_tvalid;
	assign s_axis_tready = ready_c[0];
	assign a_c[0]        = '0;
	assign q_c[0]        = s_axis_tdata[DATA_W +: WIDTH];
	assign qp_c[0]       = 1'b0;
	assign m_c[0]        = s_axis_tdata[WIDTH-1:0];

	// row of booth cells
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		brm_cell #(.W(WIDTH)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_a      (a_c[i]),
			.in_q      (q_c[i]),
			.in_qp     (qp_c[i]),
			.in_m      (m_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_a     (a_c[i+1]),
			.out_q     (q_c[i+1]),
			.out_qp    (qp_c[i+1]),
			.out_m     (m_c[i+1])
		);
	end

	// last cell is the output register; product is A:Q sign-extended or truncated to PROD_W bits
	assign ready_c[WIDTH] = m_axis_tready;
	assign m_axis_tvalid  = valid_c[WIDTH];
	assign full_prod      = {a_c[WIDTH], q_c[WIDTH]};
	assign ext_prod       = (PROD_W + 1)'(signed'(full_prod));
	assign m_axis_tdata   = ext_prod[PROD_W-1:0];

	// an empty output stage means the whole row can take an item
	`BRM_ASSERT(a_ready_when_out_empty, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with an empty output stage")
	// an accepted item lands in the first cell
	`BRM_ASSERT(a_accept_fills_head, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> valid_c[1], "accepted item lost at the first cell")
	// the first cell records multiplier bit 0 as Q-1
	`BRM_ASSERT(a_head_qprev, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> (qp_c[1] == $past(s_axis_tdata[DATA_W])), "first cell Q-1 does not match multiplier bit 0")

endmodule
